[rtl/core/svm_pkg.sv]
// Shared types and constants for the sample playback voice mixer.
// Item structs, command codes, register indexes, controller states.
// No dependencies.
package svm_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_RENDER = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [2:0] CFG_MASTER_AMP   = 3'd0;
    localparam logic [2:0] CFG_LEFT_VOLUME  = 3'd1;
    localparam logic [2:0] CFG_RIGHT_VOLUME = 3'd2;
    localparam logic [2:0] CFG_STEP_INC     = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_LEN   = 3'd4;
    localparam logic [2:0] CFG_LOOPING      = 3'd5;
    localparam logic [2:0] CFG_SIXTEEN_BIT  = 3'd6;

    // Register reset values
    localparam logic [8:0]  MASTER_AMP_RST = 9'd256;
    localparam logic [63:0] STEP_INC_RST   = 64'h0000_0001_0000_0000;

    // Saturation limits of the clipped outputs
    localparam logic signed [15:0] CLIP_MAX = 16'sh7FFF;
    localparam logic signed [15:0] CLIP_MIN = 16'sh8000;

    typedef struct packed {
        t_cmd               command;
        logic [13:0]        load_address;
        logic signed [15:0] load_value;
        logic signed [31:0] acc_left_in;
        logic signed [31:0] acc_right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] acc_left_out;
        logic signed [31:0] acc_right_out;
        logic signed [15:0] clipped_left;
        logic signed [15:0] clipped_right;
        logic               playing;
    } t_out_item;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_MIX
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mult;
        logic mix;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

[rtl/core/svm_ctrl.sv]
// Sequencer for the voice mixer: accept, multiply, mix-and-commit.
// Depends on svm_pkg.
module svm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  svm_pkg::t_dp_status i_status,
    output svm_pkg::t_ctrl_cmd  o_cmd,
    output logic                o_in_stall
);
    import svm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MULT;
                end
            end
            ST_MULT: begin
                n_state = ST_MIX;
            end
            ST_MIX: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs; input stays stalled while reset is held
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = !i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
            end
            ST_MIX: begin
                o_cmd.mix = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Sequencing checks
    a_accept_then_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.mult)
        else $error("accepted transfer not followed by multiply");
    a_mult_then_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mult |=> (r_state == ST_MIX))
        else $error("multiply not followed by mix state");
    a_mix_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX) && !i_status.out_free |=> (r_state == ST_MIX))
        else $error("mix state left while output register busy");

endmodule

[rtl/core/svm_datapath.sv]
// Datapath for the voice mixer: config registers, sample store, gain and
// sample multiply, accumulate, position update, output register.
// Depends on svm_pkg.
module svm_datapath #(
    parameter int SAMPLE_DEPTH = 16384
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svm_pkg::t_ctrl_cmd  i_cmd,
    output svm_pkg::t_dp_status o_status,
    input  svm_pkg::t_in_item   i_in_item,
    input  logic                i_cfg_write,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output svm_pkg::t_out_item  o_out_item
);
    import svm_pkg::*;

    localparam int          ADDR_W  = $clog2(SAMPLE_DEPTH);
    localparam logic [31:0] DEPTH32 = 32'(SAMPLE_DEPTH);

    // Configuration registers
    logic [8:0]  r_master_amp;
    logic [7:0]  r_left_vol;
    logic [7:0]  r_right_vol;
    logic [63:0] r_step;
    logic [14:0] r_length;
    logic        r_looping;
    logic        r_sixteen;

    // Voice state
    logic [63:0] r_pos;
    logic        r_active;
    logic [63:0] n_pos;
    logic        n_active;

    // Item pipeline
    t_in_item    r_item;
    logic [15:0] r_raw;
    logic        r_oob;
    logic        r_do_mix;
    logic [16:0] r_gain_l;
    logic [16:0] r_gain_r;
    logic [31:0] r_prod_l;
    logic [31:0] r_prod_r;
    logic [63:0] r_pos_sum;

    // Output register
    t_out_item   r_out;
    logic        r_out_valid;

    // Sample store
    logic [15:0] r_store [SAMPLE_DEPTH];

    logic [31:0]        pos_hi;
    logic               rd_oob;
    logic [31:0]        load_addr32;
    logic               store_we;
    logic [16:0]        gain_l_full;
    logic [16:0]        gain_r_full;
    logic signed [15:0] smp;
    logic signed [33:0] prod_l_full;
    logic signed [33:0] prod_r_full;
    logic signed [31:0] acc_l;
    logic signed [31:0] acc_r;
    logic [31:0]        sum_hi;
    logic               at_end;

    // Arithmetic shift by 2 and saturate to 16 bits
    function automatic logic signed [15:0] clip16(input logic signed [31:0] acc);
        logic signed [15:0] res;
        if ((acc[31:17] == '0) || (acc[31:17] == '1)) begin
            res = acc[17:2];
        end else if (acc[31]) begin
            res = CLIP_MIN;
        end else begin
            res = CLIP_MAX;
        end
        return res;
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_amp <= MASTER_AMP_RST;
            r_left_vol   <= '0;
            r_right_vol  <= '0;
            r_step       <= STEP_INC_RST;
            r_length     <= '0;
            r_looping    <= 1'b0;
            r_sixteen    <= 1'b0;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_MASTER_AMP:   r_master_amp <= i_cfg_data[8:0];
                CFG_LEFT_VOLUME:  r_left_vol   <= i_cfg_data[7:0];
                CFG_RIGHT_VOLUME: r_right_vol  <= i_cfg_data[7:0];
                CFG_STEP_INC:     r_step       <= i_cfg_data;
                CFG_SAMPLE_LEN:   r_length     <= i_cfg_data[14:0];
                CFG_LOOPING:      r_looping    <= i_cfg_data[0];
                CFG_SIXTEEN_BIT:  r_sixteen    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Store addressing
    assign pos_hi      = r_pos[63:32];
    assign rd_oob      = (pos_hi >= DEPTH32);
    assign load_addr32 = 32'(i_in_item.load_address);
    assign store_we    = i_cmd.accept && (i_in_item.command == CMD_LOAD)
                         && (load_addr32 < DEPTH32);

    // Sample store write port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[load_addr32[ADDR_W-1:0]] <= i_in_item.load_value;
        end
    end

    // Sample store read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !rd_oob) begin
            r_raw <= r_store[pos_hi[ADDR_W-1:0]];
        end
    end

    // Gains from the volume registers
    assign gain_l_full = 17'(r_left_vol) * 17'(r_master_amp);
    assign gain_r_full = 17'(r_right_vol) * 17'(r_master_amp);

    // Accept stage: capture item, gains and mix enable
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item   <= i_in_item;
            r_oob    <= rd_oob;
            r_gain_l <= r_sixteen ? (gain_l_full >> 8) : gain_l_full;
            r_gain_r <= r_sixteen ? (gain_r_full >> 8) : gain_r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_do_mix <= 1'b0;
        end else if (i_cmd.accept) begin
            r_do_mix <= (i_in_item.command == CMD_RENDER) && r_active
                        && ((r_left_vol | r_right_vol) != '0);
        end
    end

    // Multiply stage: sample times gain, position step
    always_comb begin
        if (r_oob) begin
            smp = '0;
        end else if (r_sixteen) begin
            smp = r_raw;
        end else begin
            smp = {{8{r_raw[7]}}, r_raw[7:0]};
        end
    end

    assign prod_l_full = smp * $signed({1'b0, r_gain_l});
    assign prod_r_full = smp * $signed({1'b0, r_gain_r});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod_l  <= prod_l_full[31:0];
            r_prod_r  <= prod_r_full[31:0];
            r_pos_sum <= r_pos + r_step;
        end
    end

    // Mix stage: accumulate, wrap at 32 bits
    assign acc_l = r_item.acc_left_in  + (r_do_mix ? $signed(r_prod_l) : 32'sd0);
    assign acc_r = r_item.acc_right_in + (r_do_mix ? $signed(r_prod_r) : 32'sd0);

    // End of sample test and voice state update
    assign sum_hi = r_pos_sum[63:32];
    assign at_end = (sum_hi >= 32'(r_length));

    always_comb begin
        n_pos    = r_pos;
        n_active = r_active;
        unique case (r_item.command)
            CMD_START: begin
                n_pos    = '0;
                n_active = 1'b1;
            end
            CMD_STOP: begin
                n_active = 1'b0;
            end
            CMD_RENDER: begin
                if (r_do_mix) begin
                    n_pos = r_pos_sum;
                    if (at_end) begin
                        if (r_looping) begin
                            n_pos = {sum_hi - 32'(r_length), r_pos_sum[31:0]};
                        end else begin
                            n_active = 1'b0;
                        end
                    end
                end
            end
            CMD_LOAD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.mix) begin
            r_pos    <= n_pos;
            r_active <= n_active;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_out.acc_left_out  <= acc_l;
            r_out.acc_right_out <= acc_r;
            r_out.clipped_left  <= clip16(acc_l);
            r_out.clipped_right <= clip16(acc_r);
            r_out.playing       <= n_active;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.mix) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

    // Datapath checks
    a_mix_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mix |=> r_out_valid)
        else $error("mix did not load the output register");
    a_idle_voice_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && !r_active |=> !r_do_mix)
        else $error("inactive voice enabled for mixing");
    a_stop_clears_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mix && (r_item.command == CMD_STOP) |=> !r_active && !r_out.playing)
        else $error("stop transfer left the voice active");

endmodule

[rtl/core/sample_playback_voice_mixer_core.sv]
// Top level of the sample playback voice mixer.
// Instantiates svm_ctrl and svm_datapath; depends on svm_pkg.
//
// Every input transfer has three steps: the accept cycle reads the sample
// store at the integer part of the play position, the next cycle multiplies
// the sample by the left and right gains and steps the position, and the
// third adds the products to the accumulators, applies the end-of-sample
// test and loads the output register. That three-step sequence through the
// single store read port and the gain multipliers sets the rate; the input
// is taken again the cycle after. The output register lets a new item be
// accepted while the last result waits; a result that is still stalled at
// the mix step holds the sequence there. Loads, start and stop go through the
// same steps and also produce one result. The sample store has no reset;
// configuration is written through a separate port that is always ready.
module sample_playback_voice_mixer_core #(
    parameter int SAMPLE_DEPTH = 16384
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  svm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output svm_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import svm_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    svm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath and sample store
    svm_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
